// ----- src/ctok_pkg.sv -----
// shared types and constants of the c word tokenizer
`default_nettype none

package ctok_pkg;

   // word kinds as carried on the result side
   localparam logic [1:0] KIND_IDENT  = 2'd0;
   localparam logic [1:0] KIND_CLIT   = 2'd1;
   localparam logic [1:0] KIND_SLIT   = 2'd2;
   localparam logic [1:0] KIND_SINGLE = 2'd3;

   // characters with a meaning of their own
   localparam logic [7:0] CH_HASH   = 8'h23;
   localparam logic [7:0] CH_UNDER  = 8'h5F;
   localparam logic [7:0] CH_STAR   = 8'h2A;
   localparam logic [7:0] CH_SLASH  = 8'h2F;
   localparam logic [7:0] CH_SQUOTE = 8'h27;
   localparam logic [7:0] CH_DQUOTE = 8'h22;

   localparam int          LIMIT_W     = 10;
   localparam logic [9:0]  LIMIT_RESET = 10'd100;
   localparam int          QUEUE_DEPTH = 4;

   // one result character
   typedef struct packed {
      logic [7:0] ch;
      logic [1:0] kind;
      logic       word_end;
   } res_type;

   // results caused by one input item: first, and second when two is set
   typedef struct packed {
      logic    two;
      res_type r0;
      res_type r1;
   } rec_type;

   // queue status seen by the front and the back
   typedef struct packed {
      logic full;
      logic empty;
   } qstat_type;

endpackage

`default_nettype wire

// ----- src/c_word_tokenizer.sv -----
// top level of the c word tokenizer: front scanner, record queue, output stage
//
//  channel | direction | tdata              | tuser                        | tlast
//  req_    | in        | [7:0] in_char      | -                            | end_of_input
//  rsp_    | out       | [7:0] out_char     | [1:0] word_kind, [2] word_end | run_last
//  csr_    | in        | word_limit, 10 bits written on csr_wr_en           | -
//
// one item a cycle is accepted while the record queue has a free slot
// each item yields zero, one or two results, sent one a cycle from the output register,
// so one item a cycle holds unless rsp_ stalls or results exceed one a cycle on average
// synchronous reset clears scanner state and queue, word_limit returns to 100
// a stalled rsp_ side fills the queue of QDEPTH records before req_tready drops
`default_nettype none

module c_word_tokenizer #(
   parameter int QDEPTH = ctok_pkg::QUEUE_DEPTH
) (
   input  wire                          clock,
   input  wire                          reset,
   // configuration
   input  wire                          csr_wr_en,
   input  wire  [ctok_pkg::LIMIT_W-1:0] csr_wr_data,  // word_limit
   // input characters
   input  wire                          req_tvalid,
   output logic                         req_tready,
   input  wire  [7:0]                   req_tdata,    // [7:0] in_char
   input  wire                          req_tlast,    // end_of_input
   // result characters
   output logic                         rsp_tvalid,
   input  wire                          rsp_tready,
   output logic [7:0]                   rsp_tdata,    // [7:0] out_char
   output logic [2:0]                   rsp_tuser,    // [1:0] word_kind, [2] word_end
   output logic                         rsp_tlast     // run_last
);
   import ctok_pkg::*;

   // front to queue
   logic      push;
   rec_type   push_rec;
   // queue to back
   logic      pop;
   rec_type   head_rec;
   qstat_type qstat;

   // scanner: classifies each character and forms its results
   ctok_front u_front (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .in_valid    (req_tvalid),
      .in_char     (req_tdata),
      .in_eoi      (req_tlast),
      .in_ready    (req_tready),
      .qstat       (qstat),
      .push        (push),
      .push_rec    (push_rec)
   );

   // records of one or two results, decoupling the two sides
   ctok_queue #(
      .DEPTH (QDEPTH)
   ) u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_rec (push_rec),
      .pop      (pop),
      .head_rec (head_rec),
      .qstat    (qstat)
   );

   // output stage: one result a cycle while rsp_tready is high
   ctok_back u_back (
      .clock     (clock),
      .reset     (reset),
      .head_rec  (head_rec),
      .qstat     (qstat),
      .pop       (pop),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_char  (rsp_tdata),
      .out_kind  (rsp_tuser[1:0]),
      .out_end   (rsp_tuser[2]),
      .out_last  (rsp_tlast)
   );

endmodule

`default_nettype wire

// ----- src/ctok_front.sv -----
// front part: takes characters, runs the scanner and builds result records
`default_nettype none

module ctok_front (
   input  wire                         clock,
   input  wire                         reset,
   input  wire                         csr_wr_en,
   input  wire  [ctok_pkg::LIMIT_W-1:0] csr_wr_data,
   input  wire                         in_valid,
   input  wire  [7:0]                  in_char,
   input  wire                         in_eoi,
   output logic                        in_ready,
   input  ctok_pkg::qstat_type         qstat,
   output logic                        push,
   output ctok_pkg::rec_type           push_rec
);
   import ctok_pkg::*;

   localparam logic [2:0] M_IDLE    = 3'd0;
   localparam logic [2:0] M_IDENT   = 3'd1;
   localparam logic [2:0] M_CLIT    = 3'd2;
   localparam logic [2:0] M_SLIT    = 3'd3;
   localparam logic [2:0] M_SLASH   = 3'd4;
   localparam logic [2:0] M_CMT     = 3'd5;
   localparam logic [2:0] M_CMTSTAR = 3'd6;

   logic [LIMIT_W-1:0] limit_ff,  limit_in;
   logic [2:0]         mode_ff,   mode_in;
   logic [7:0]         hchar_ff,  hchar_in;
   logic               hvalid_ff, hvalid_in;
   logic [1:0]         hkind_ff,  hkind_in;
   logic [LIMIT_W-1:0] left_ff,   left_in;

   logic [LIMIT_W-1:0] room;
   logic               is_space, is_alpha, is_word;
   logic               do_fresh;
   logic [1:0]         cnt;
   res_type            r0, r1, fres;
   logic               fres_emit;
   logic [7:0]         quote;

   assign in_ready = ~qstat.full;
   wire accept = in_valid & in_ready;

   // room left for a word after its first character
   assign room = (limit_ff < LIMIT_W'(2)) ? '0 : LIMIT_W'(limit_ff - LIMIT_W'(2));

   assign is_space = (in_char inside {[8'd9:8'd13], 8'd32});
   assign is_alpha = (in_char inside {[8'd65:8'd90], [8'd97:8'd122]});
   assign is_word  = is_alpha | (in_char inside {[8'd48:8'd57]}) | (in_char == CH_UNDER);
   assign quote    = (mode_ff == M_CLIT) ? CH_SQUOTE : CH_DQUOTE;

   always_comb begin
      mode_in   = mode_ff;
      hchar_in  = hchar_ff;
      hvalid_in = hvalid_ff;
      hkind_in  = hkind_ff;
      left_in   = left_ff;
      do_fresh  = 1'b0;
      cnt       = 2'd0;
      r0        = '{ch: hchar_ff, kind: hkind_ff, word_end: 1'b1};
      r1        = '{ch: in_char, kind: hkind_ff, word_end: 1'b1};
      fres      = '{ch: in_char, kind: KIND_SINGLE, word_end: 1'b1};
      fres_emit = 1'b0;

      if (in_eoi) begin
         cnt       = hvalid_ff ? 2'd1 : 2'd0;
         hvalid_in = 1'b0;
         hchar_in  = '0;
         hkind_in  = '0;
         left_in   = '0;
         mode_in   = M_IDLE;
      end else if (!hvalid_ff) begin
         do_fresh = 1'b1;
      end else begin
         case (mode_ff)
            M_IDENT: begin
               if (is_word && left_ff != '0) begin
                  cnt         = 2'd1;
                  r0.word_end = 1'b0;
                  hchar_in    = in_char;
                  left_in     = left_ff - LIMIT_W'(1);
               end else begin
                  cnt      = 2'd1;
                  do_fresh = 1'b1;
               end
            end
            M_CLIT, M_SLIT: begin
               if (left_ff != '0) begin
                  cnt         = 2'd1;
                  r0.word_end = 1'b0;
                  if (in_char == quote) begin
                     // closing quote ends the literal at once
                     cnt       = 2'd2;
                     hvalid_in = 1'b0;
                     hchar_in  = '0;
                     hkind_in  = '0;
                     left_in   = '0;
                     mode_in   = M_IDLE;
                  end else begin
                     hchar_in = in_char;
                     left_in  = left_ff - LIMIT_W'(1);
                  end
               end else begin
                  cnt      = 2'd1;
                  do_fresh = 1'b1;
               end
            end
            M_SLASH: begin
               if (in_char == CH_STAR) begin
                  mode_in = M_CMT;
               end else begin
                  cnt     = 2'd1;
                  r0.kind = KIND_SINGLE;
                  do_fresh = 1'b1;
               end
            end
            M_CMT: begin
               if (in_char == CH_STAR) mode_in = M_CMTSTAR;
            end
            M_CMTSTAR: begin
               if (in_char == CH_SLASH) begin
                  // comment closed: it yields the word "/"
                  cnt       = 2'd1;
                  r0        = '{ch: CH_SLASH, kind: KIND_SINGLE, word_end: 1'b1};
                  hvalid_in = 1'b0;
                  hchar_in  = '0;
                  hkind_in  = '0;
                  left_in   = '0;
                  mode_in   = M_IDLE;
               end else if (in_char != CH_STAR) begin
                  mode_in = M_CMT;
               end
            end
            default: begin
               do_fresh = 1'b1;
            end
         endcase
      end

      // a character that starts afresh: nothing held, or the held word just ended
      if (do_fresh) begin
         hvalid_in = 1'b0;
         hchar_in  = '0;
         hkind_in  = '0;
         left_in   = '0;
         mode_in   = M_IDLE;
         if (is_space) begin
            hvalid_in = 1'b0;
         end else if (is_alpha || in_char == CH_HASH || in_char == CH_UNDER) begin
            hvalid_in = 1'b1;
            hchar_in  = in_char;
            hkind_in  = KIND_IDENT;
            left_in   = room;
            mode_in   = M_IDENT;
         end else if (in_char == CH_SQUOTE) begin
            hvalid_in = 1'b1;
            hchar_in  = in_char;
            hkind_in  = KIND_CLIT;
            left_in   = room;
            mode_in   = M_CLIT;
         end else if (in_char == CH_DQUOTE) begin
            hvalid_in = 1'b1;
            hchar_in  = in_char;
            hkind_in  = KIND_SLIT;
            left_in   = room;
            mode_in   = M_SLIT;
         end else if (in_char == CH_SLASH) begin
            hvalid_in = 1'b1;
            hchar_in  = in_char;
            hkind_in  = KIND_SINGLE;
            left_in   = room;
            mode_in   = M_SLASH;
         end else begin
            fres_emit = 1'b1;
         end
         if (fres_emit) begin
            if (cnt == 2'd0) begin
               r0  = fres;
               cnt = 2'd1;
            end else begin
               r1  = fres;
               cnt = 2'd2;
            end
         end
      end
   end

   assign push          = accept & (cnt != 2'd0);
   assign push_rec.two  = (cnt == 2'd2);
   assign push_rec.r0   = r0;
   assign push_rec.r1   = r1;

   assign limit_in = csr_wr_en ? csr_wr_data : limit_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         limit_ff  <= LIMIT_RESET;
         mode_ff   <= M_IDLE;
         hchar_ff  <= '0;
         hvalid_ff <= 1'b0;
         hkind_ff  <= '0;
         left_ff   <= '0;
      end else begin
         limit_ff <= limit_in;
         if (accept) begin
            mode_ff   <= mode_in;
            hchar_ff  <= hchar_in;
            hvalid_ff <= hvalid_in;
            hkind_ff  <= hkind_in;
            left_ff   <= left_in;
         end
      end
   end

endmodule

`default_nettype wire

// ----- src/ctok_queue.sv -----
// short record queue between the front and the back
`default_nettype none

module ctok_queue #(
   parameter int DEPTH = ctok_pkg::QUEUE_DEPTH
) (
   input  wire                  clock,
   input  wire                  reset,
   input  wire                  push,
   input  ctok_pkg::rec_type    push_rec,
   input  wire                  pop,
   output ctok_pkg::rec_type    head_rec,
   output ctok_pkg::qstat_type  qstat
);
   import ctok_pkg::*;

   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   rec_type        mem_ff [DEPTH];
   logic [PW-1:0]  wptr_ff, wptr_in;
   logic [PW-1:0]  rptr_ff, rptr_in;
   logic [CW-1:0]  count_ff, count_in;

   assign wptr_in  = push ? ((wptr_ff == PW'(DEPTH - 1)) ? '0 : PW'(wptr_ff + PW'(1))) : wptr_ff;
   assign rptr_in  = pop  ? ((rptr_ff == PW'(DEPTH - 1)) ? '0 : PW'(rptr_ff + PW'(1))) : rptr_ff;
   assign count_in = CW'(count_ff + CW'(push) - CW'(pop));

   assign head_rec    = mem_ff[rptr_ff];
   assign qstat.full  = (count_ff == CW'(DEPTH));
   assign qstat.empty = (count_ff == '0);

   always_ff @(posedge clock) begin
      if (push) mem_ff[wptr_ff] <= push_rec;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff  <= '0;
         rptr_ff  <= '0;
         count_ff <= '0;
      end else begin
         wptr_ff  <= wptr_in;
         rptr_ff  <= rptr_in;
         count_ff <= count_in;
      end
   end

`ifndef SYNTHESIS
   a_count_range : assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(DEPTH))
      else $error("queue count beyond depth");
   a_no_overrun : assert property (@(posedge clock) disable iff (reset)
      push |-> (count_ff < CW'(DEPTH)) || pop)
      else $error("record pushed into full queue");
   a_no_underrun : assert property (@(posedge clock) disable iff (reset)
      pop |-> count_ff != '0)
      else $error("record popped from empty queue");
   a_ptr_track : assert property (@(posedge clock) disable iff (reset)
      (count_ff == '0) |-> (wptr_ff == rptr_ff))
      else $error("empty queue with unequal pointers");
`endif

endmodule

`default_nettype wire

// ----- src/ctok_back.sv -----
// back part: splits records into result items and holds the output register
`default_nettype none

module ctok_back (
   input  wire                  clock,
   input  wire                  reset,
   input  ctok_pkg::rec_type    head_rec,
   input  ctok_pkg::qstat_type  qstat,
   output logic                 pop,
   output logic                 out_valid,
   input  wire                  out_ready,
   output logic [7:0]           out_char,
   output logic [1:0]           out_kind,
   output logic                 out_end,
   output logic                 out_last
);
   import ctok_pkg::*;

   logic    valid_ff, valid_in;
   logic    sel_ff,   sel_in;
   res_type res_ff;
   logic    last_ff;
   res_type pick;
   logic    pick_last;
   logic    load;

   assign load      = (~valid_ff | out_ready) & ~qstat.empty;
   assign pick      = sel_ff ? head_rec.r1 : head_rec.r0;
   assign pick_last = sel_ff | ~head_rec.two;
   assign pop       = load & pick_last;
   assign valid_in  = load | (valid_ff & ~out_ready);
   assign sel_in    = load ? ~pick_last : sel_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         sel_ff   <= 1'b0;
      end else begin
         valid_ff <= valid_in;
         sel_ff   <= sel_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         res_ff  <= pick;
         last_ff <= pick_last;
      end
   end

   assign out_valid = valid_ff;
   assign out_char  = res_ff.ch;
   assign out_kind  = res_ff.kind;
   assign out_end   = res_ff.word_end;
   assign out_last  = last_ff;

endmodule

`default_nettype wire
